// ----- rtl/core/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants and types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CapW    = 5;
  localparam int unsigned OccW    = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW    = (OccW > CapW) ? OccW : CapW;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic {
    ReqGet = 1'b0,
    ReqPut = 1'b1
  } req_type_e;

  // one stored pair, handed down the chain
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  // request broadcast to every cell
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            apply;
    logic            insert;
  } req_t;

  // lookup result rippling from the most recent cell to the least
  typedef struct packed {
    logic            passed;
    logic [ValW-1:0] hit_value;
  } chain_t;

endpackage

// ----- rtl/core/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o): req_type_i selects get or put,
//   lookup_key_i is the key, put_value_i the value written by a put.
//   Result channel (out_valid_o/out_ready_i): found_o, read_value_o and
//   evicted_o, one result per request, in request order.
//   Entries sit in a chain of cells ordered by recency, most recent first.
//   A request is compared against every cell and the chain shifts by one
//   in the same cycle, and its result is registered and shown in the next
//   cycle; one request per cycle is sustained while results are taken.
//   The result register decouples the sides: a new request is taken while
//   the held result is being taken; while the receiver stalls with a
//   result held, in_ready_o stays low.
//   cfg_we_i/cfg_wdata_i write the capacity (0 acts as 1, values above the
//   entry count act as the entry count); write only while idle.
//   Reset empties the cache and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [lkvc_pkg::KeyW-1:0]   lookup_key_i,
  input  logic [lkvc_pkg::ValW-1:0]   put_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [lkvc_pkg::ValW-1:0]   read_value_o,
  output logic                        evicted_o,
  input  logic                        cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]   cfg_wdata_i
);

  logic [lkvc_pkg::CapW-1:0] cap_q, cap_d;
  logic [lkvc_pkg::OccW-1:0] occ_q, occ_d;
  logic                      out_valid_q, out_valid_d;
  logic                      found_q, found_d;
  logic [lkvc_pkg::ValW-1:0] rdval_q, rdval_d;
  logic                      evict_q, evict_d;

  lkvc_pkg::entry_t ent [lkvc_pkg::ENTRIES];
  lkvc_pkg::chain_t chn [lkvc_pkg::ENTRIES+1];
  lkvc_pkg::entry_t new_ent;
  lkvc_pkg::req_t   req;

  logic                      accept;
  logic                      is_put;
  logic                      hit;
  logic                      full;
  logic [lkvc_pkg::CmpW-1:0] cap_ext, eff_cap;
  logic [lkvc_pkg::ENTRIES-1:0] valid_vec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_put     = (req_type_i == lkvc_pkg::ReqPut);

  assign chn[0].passed    = 1'b0;
  assign chn[0].hit_value = '0;
  assign hit              = chn[lkvc_pkg::ENTRIES].passed;

  always_comb begin
    cap_ext = lkvc_pkg::CmpW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = lkvc_pkg::CmpW'(1);
    end else if (cap_ext > lkvc_pkg::CmpW'(lkvc_pkg::ENTRIES)) begin
      eff_cap = lkvc_pkg::CmpW'(lkvc_pkg::ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full = lkvc_pkg::CmpW'(occ_q) >= eff_cap;

  assign req.key    = lookup_key_i;
  assign req.apply  = accept && (is_put || hit);
  assign req.insert = is_put && !hit && !full;

  assign new_ent.valid = 1'b1;
  assign new_ent.key   = lookup_key_i;
  assign new_ent.value = is_put ? put_value_i : chn[lkvc_pkg::ENTRIES].hit_value;

  for (genvar i = 0; i < lkvc_pkg::ENTRIES; i++) begin : g_cell
    lkvc_pkg::entry_t up;
    if (i == 0) begin : g_head
      assign up = new_ent;
    end else begin : g_body
      assign up = ent[i-1];
    end
    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req),
      .up_i    (up),
      .chain_i (chn[i]),
      .chain_o (chn[i+1]),
      .ent_o   (ent[i])
    );
    assign valid_vec[i] = ent[i].valid;
  end

  always_comb begin
    cap_d       = cap_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    rdval_d     = rdval_q;
    evict_d     = evict_q;
    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      found_d     = hit;
      rdval_d     = (!is_put && hit) ? chn[lkvc_pkg::ENTRIES].hit_value : '0;
      evict_d     = is_put && !hit && full;
      if (req.insert) begin
        occ_d = occ_q + lkvc_pkg::OccW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkvc_pkg::CapReset;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    rdval_q <= rdval_d;
    evict_q <= evict_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = rdval_q;
  assign evicted_o    = evict_q;

  // valid cells form a prefix of the chain, as long as the count
  a_occ_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(occ_q))
    else $error("occupancy does not match valid cells");

  a_insert_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.apply && req.insert) |-> !ent[lkvc_pkg::ENTRIES-1].valid)
    else $error("insert with a full chain");

  a_evict_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && evicted_o))
    else $error("eviction reported on a hit");

  a_evict_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_put) |=> (read_value_o == '0))
    else $error("put returned a value");

endmodule

// ----- rtl/core/lkvc_cell.sv -----
// ----------------------------------------------------------------------------
// lkvc_cell
// One recency slot: compares its key, and on update takes the entry of its
// more recent neighbour.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkvc_pkg::req_t   req_i,
  input  lkvc_pkg::entry_t up_i,
  input  lkvc_pkg::chain_t chain_i,
  output lkvc_pkg::chain_t chain_o,
  output lkvc_pkg::entry_t ent_o
);

  logic                      valid_q, valid_d;
  logic [lkvc_pkg::KeyW-1:0] key_q, key_d;
  logic [lkvc_pkg::ValW-1:0] value_q, value_d;
  logic                      hit;
  logic                      upd;

  assign hit = valid_q && (key_q == req_i.key);
  assign upd = req_i.apply && !chain_i.passed && (req_i.insert || valid_q);

  assign chain_o.passed    = chain_i.passed | hit;
  assign chain_o.hit_value = chain_i.hit_value | (hit ? value_q : '0);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (upd) begin
      valid_d = up_i.valid;
      key_d   = up_i.key;
      value_d = up_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign ent_o.valid = valid_q;
  assign ent_o.key   = key_q;
  assign ent_o.value = value_q;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_key_value_cache_top. A scoreboard keeps its own
// recency-ranked copy of the store and works out found, read value and
// eviction for each accepted request. Results are checked in order. The run
// covers directed corner requests, then random get/put traffic over small key
// pools across several capacity settings, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 80;

  typedef struct packed {
    logic                      found;
    logic [lkvc_pkg::ValW-1:0] read_value;
    logic                      evicted;
  } lookup_result_t;

  class lru_scoreboard;
    lookup_result_t            expected_q[$];
    logic [lkvc_pkg::CapW-1:0] capacity;
    bit                        slot_valid[lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::KeyW-1:0] slot_key[lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::ValW-1:0] slot_value[lkvc_pkg::ENTRIES];
    int unsigned               slot_rank[lkvc_pkg::ENTRIES];
    int unsigned               occupancy;
    int unsigned               errors;

    function new();
      capacity  = lkvc_pkg::CapReset;
      occupancy = 0;
      errors    = 0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
    endfunction

    function void set_capacity(logic [lkvc_pkg::CapW-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // age every valid entry newer than slot s, then make s the most recent
    function void make_recent(int unsigned s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
      slot_rank[s] = 0;
    endfunction

    function void note_request(lkvc_pkg::req_type_e kind, logic [lkvc_pkg::KeyW-1:0] key,
                               logic [lkvc_pkg::ValW-1:0] value);
      lookup_result_t res;
      int unsigned    hit_slot;
      int unsigned    slot;
      int unsigned    eff_cap;
      int unsigned    oldest;
      bit             have;
      res      = '0;
      hit_slot = 0;
      slot     = 0;
      oldest   = 0;
      have     = 1'b0;
      eff_cap  = (capacity == 0) ? 1 :
                 ((capacity > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : capacity);
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (!res.found && slot_valid[i] && slot_key[i] == key) begin
          res.found = 1'b1;
          hit_slot  = i;
        end
      end
      if (res.found) begin
        if (kind == lkvc_pkg::ReqPut) slot_value[hit_slot] = value;
        else res.read_value = slot_value[hit_slot];
        make_recent(hit_slot);
      end else if (kind == lkvc_pkg::ReqPut) begin
        if (occupancy >= eff_cap && occupancy > 0) begin
          for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && (!have || slot_rank[i] > oldest)) begin
              oldest = slot_rank[i];
              slot   = i;
              have   = 1'b1;
            end
          end
          res.evicted = 1'b1;
          make_recent(slot);
        end else begin
          for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--)
            if (!slot_valid[i]) slot = i;
          for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (slot_valid[i]) slot_rank[i]++;
          occupancy++;
        end
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = value;
        slot_rank[slot]  = 0;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found %0b value %08h evicted %0b",
                   got.found, got.read_value, got.evicted);
        return;
      end
      exp = expected_q.pop_front();
      if (got.found !== exp.found || got.read_value !== exp.read_value ||
          got.evicted !== exp.evicted) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: found %0b/%0b value %08h/%08h evicted %0b/%0b (exp/act)",
                   exp.found, got.found, exp.read_value, got.read_value,
                   exp.evicted, got.evicted);
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready;
  logic                      req_type;
  logic [lkvc_pkg::KeyW-1:0] lookup_key;
  logic [lkvc_pkg::ValW-1:0] put_value;
  logic                      out_valid;
  logic                      out_ready;
  logic                      found;
  logic [lkvc_pkg::ValW-1:0] read_value;
  logic                      evicted;
  logic                      cfg_we;
  logic [lkvc_pkg::CapW-1:0] cfg_wdata;

  lru_scoreboard             sb;
  int unsigned               tx_idle_pct;
  int unsigned               rx_stall_pct;
  int unsigned               hold_left;
  int unsigned               quiet_cycles;
  logic [lkvc_pkg::KeyW-1:0] key_pool[64];

  lru_key_value_cache_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .lookup_key_i (lookup_key),
    .put_value_i  (put_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .read_value_o (read_value),
    .evicted_o    (evicted),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result check first: a result never belongs to a request taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        sb.check_result('{found: found, read_value: read_value, evicted: evicted});
        quiet_cycles = 0;
      end
      if (in_valid && in_ready) begin
        sb.note_request(lkvc_pkg::req_type_e'(req_type), lookup_key, put_value);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_request(lkvc_pkg::req_type_e kind, logic [lkvc_pkg::KeyW-1:0] key,
                              logic [lkvc_pkg::ValW-1:0] value);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    lookup_key <= key;
    put_value  <= value;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // wait on the clock first so the last accepted request is already on the scoreboard
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CapW-1:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_capacity(cap);
  endtask

  task automatic run_random(logic [lkvc_pkg::CapW-1:0] cap, int unsigned count,
                            int unsigned tx_pct, int unsigned rx_pct,
                            int unsigned pool_n, bit hold_off);
    logic [lkvc_pkg::KeyW-1:0] key;
    write_capacity(cap);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < pool_n; i++) key_pool[i] = lkvc_pkg::KeyW'($urandom);
    if (hold_off) hold_left = HoldOffCycles;
    for (int n = 0; n < count; n++) begin
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)]
                                      : lkvc_pkg::KeyW'($urandom);
      send_request(($urandom_range(99) < 50) ? lkvc_pkg::ReqPut : lkvc_pkg::ReqGet,
                   key, lkvc_pkg::ValW'($urandom));
    end
  endtask

  initial begin
    sb           = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    req_type   <= lkvc_pkg::ReqGet;
    lookup_key <= '0;
    put_value  <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, key extremes, overwrite, ignored value on get
    send_request(lkvc_pkg::ReqGet, 16'h0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::ReqGet, 16'hFFFF, 32'h0000_0000);
    send_request(lkvc_pkg::ReqPut, 16'h0000, 32'h0000_0000);
    send_request(lkvc_pkg::ReqPut, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::ReqGet, 16'h0000, 32'hA5A5_A5A5);
    send_request(lkvc_pkg::ReqGet, 16'hFFFF, 32'h0000_0000);
    send_request(lkvc_pkg::ReqPut, 16'hFFFF, 32'h5A5A_5A5A);
    send_request(lkvc_pkg::ReqGet, 16'hFFFF, 32'hFFFF_FFFF);

    // capacity two: least recent goes first
    write_capacity(lkvc_pkg::CapW'(2));
    send_request(lkvc_pkg::ReqPut, 16'h1234, 32'h1111_1111);
    send_request(lkvc_pkg::ReqGet, 16'hFFFF, 32'h0);
    send_request(lkvc_pkg::ReqPut, 16'h4321, 32'h2222_2222);
    send_request(lkvc_pkg::ReqGet, 16'h1234, 32'h0);
    send_request(lkvc_pkg::ReqGet, 16'hFFFF, 32'h0);
    send_request(lkvc_pkg::ReqPut, 16'h4321, 32'h3333_3333);

    // capacity one: every put miss evicts
    write_capacity(lkvc_pkg::CapW'(1));
    send_request(lkvc_pkg::ReqPut, 16'h00AA, 32'hDEAD_BEEF);
    send_request(lkvc_pkg::ReqPut, 16'h0055, 32'hCAFE_F00D);
    send_request(lkvc_pkg::ReqGet, 16'h00AA, 32'h0);
    send_request(lkvc_pkg::ReqGet, 16'h0055, 32'h0);

    run_random(lkvc_pkg::CapW'(16), 200, 0,  0,  24, 1'b1);
    run_random(lkvc_pkg::CapW'(3),  200, 53, 0,  12, 1'b0);
    run_random(lkvc_pkg::CapW'(1),  150, 0,  53, 6,  1'b0);
    run_random(lkvc_pkg::CapW'(0),  150, 22, 22, 6,  1'b0);
    run_random(lkvc_pkg::CapW'(31), 250, 0,  0,  40, 1'b1);
    run_random(lkvc_pkg::CapW'(20), 200, 53, 0,  30, 1'b0);
    run_random(lkvc_pkg::CapW'(8),  200, 0,  53, 16, 1'b0);
    run_random(lkvc_pkg::CapW'(16), 200, 22, 22, 20, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
